[rtl/eotp_pkg.sv]
// Shared types, result codes and constants of the EDNS option TLV parser.
package eotp_pkg;

   localparam int unsigned AreaSizeWidth = 16;
   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned CodeWidth     = 16;
   localparam int unsigned KindWidth     = 3;
   localparam int unsigned MaxResults    = 4;
   localparam int unsigned ResIdxWidth   = $clog2(MaxResults);

   localparam int unsigned MIN_OPTION_HEADER = 4;

   // Input item kinds.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   // Result kinds.
   localparam logic [KindWidth-1:0] RK_NSID   = 3'd0;
   localparam logic [KindWidth-1:0] RK_ALG    = 3'd1;
   localparam logic [KindWidth-1:0] RK_OTHER  = 3'd2;
   localparam logic [KindWidth-1:0] RK_DONE   = 3'd3;
   localparam logic [KindWidth-1:0] RK_SHORT  = 3'd4;
   localparam logic [KindWidth-1:0] RK_BADLEN = 3'd5;

   // Option codes with special handling.
   localparam logic [CodeWidth-1:0] OPT_NSID = 16'd3;
   localparam logic [CodeWidth-1:0] OPT_DAU  = 16'd5;
   localparam logic [CodeWidth-1:0] OPT_DHU  = 16'd6;
   localparam logic [CodeWidth-1:0] OPT_N3U  = 16'd7;

   localparam logic [ByteWidth-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [ByteWidth-1:0] ASCII_COMMA = 8'h2C;
   localparam logic [ByteWidth-1:0] HUNDRED     = 8'd100;
   localparam logic [ByteWidth-1:0] TWO_HUNDRED = 8'd200;
   localparam logic [ByteWidth-1:0] TEN         = 8'd10;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [CodeWidth-1:0] code;
      logic [ByteWidth-1:0] value;
   } result_type;

   // All results caused by one input beat, in order.
   typedef struct packed {
      logic [ResIdxWidth-1:0]           last_idx;
      result_type [MaxResults-1:0]      res;
   } bundle_type;

endpackage

[rtl/eotp_if.sv]
// Valid/ready channel interfaces for option area bytes and parse results.
interface eotp_req_if import eotp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [AreaSizeWidth-1:0] area_size;
   logic [ByteWidth-1:0]     data_byte;

   modport source (output valid, kind, area_size, data_byte, input ready);
   modport sink   (input valid, kind, area_size, data_byte, output ready);
endinterface

interface eotp_rsp_if import eotp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] result_kind;
   logic [CodeWidth-1:0] tlv_code;
   logic [ByteWidth-1:0] value;
   logic                 last;

   modport source (output valid, result_kind, tlv_code, value, last, input ready);
   modport sink   (input valid, result_kind, tlv_code, value, last, output ready);
endinterface

[rtl/edns_option_tlv_parser_core.sv]
// Latency: the first result of a byte or start beat is offered in the cycle after it is
// accepted when the result queue is empty; results queued earlier leave first.
// Throughput: one input beat per cycle while beats yield at most one result and results are
// taken; a beat with more results holds the single result port, and input stalls when both slots fill.
// Reset (synchronous, active high) returns the walker to idle with all counters cleared
// and empties the result queue.
module edns_option_tlv_parser_core import eotp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   eotp_req_if.sink   req_chan,
   eotp_rsp_if.source rsp_chan
);

   logic       accept;
   logic       push;
   logic       space;
   bundle_type bundle;

   assign req_chan.ready = space;
   assign accept         = req_chan.valid && req_chan.ready;

   eotp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_chan.kind),
      .area_size (req_chan.area_size),
      .data_byte (req_chan.data_byte),
      .push      (push),
      .bundle    (bundle)
   );

   eotp_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (bundle),
      .space       (space),
      .rsp         (rsp_chan)
   );

   // The queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result offered right after reset");

   // A beat taken that is not the last of its bundle leaves more results pending.
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=> rsp_chan.valid)
      else $error("bundle cut short");

   // Done and short header results carry no option code.
   a_end_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && ((rsp_chan.result_kind == RK_DONE) ||
                          (rsp_chan.result_kind == RK_SHORT))) |-> (rsp_chan.tlv_code == '0))
      else $error("end result with nonzero code");

   // NSID data results belong to the NSID option only.
   a_nsid_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.result_kind == RK_NSID)) |-> (rsp_chan.tlv_code == OPT_NSID))
      else $error("NSID byte under another code");

endmodule

[rtl/eotp_parser.sv]
// Option TLV walker: per-beat state update and result bundle generation.
module eotp_parser import eotp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     kind,
   input  logic [AreaSizeWidth-1:0] area_size,
   input  logic [ByteWidth-1:0]     data_byte,
   output logic                     push,
   output bundle_type               bundle
);

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_CODE_HI = 3'd1;
   localparam logic [2:0] PH_CODE_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI  = 3'd3;
   localparam logic [2:0] PH_LEN_LO  = 3'd4;
   localparam logic [2:0] PH_DATA    = 3'd5;

   localparam logic [AreaSizeWidth-1:0] MinHeader = AreaSizeWidth'(MIN_OPTION_HEADER);

   logic [2:0]               phase_ff, phase_in;
   logic [AreaSizeWidth-1:0] bytes_rem_ff, bytes_rem_in;
   logic [CodeWidth-1:0]     code_ff, code_in;
   logic [AreaSizeWidth-1:0] data_rem_ff, data_rem_in;
   logic [ByteWidth-1:0]     len_hi_ff, len_hi_in;

   logic [AreaSizeWidth-1:0] bytes_dec;
   logic [AreaSizeWidth-1:0] data_dec;
   logic [AreaSizeWidth-1:0] opt_len;
   logic                     alg_list;

   // Decimal digits of the data byte.
   logic [1:0]           hund;
   logic [ByteWidth-1:0] hund_sub;
   logic [ByteWidth-1:0] rem;
   logic [15:0]          tens_prod;
   logic [3:0]           tens;
   logic [ByteWidth-1:0] tens_x10;
   logic [ByteWidth-1:0] ones;

   logic                 do_boundary;
   logic [2:0]           n;
   result_type [MaxResults-1:0] res;

   function automatic result_type make_res(logic [KindWidth-1:0] k,
                                           logic [CodeWidth-1:0] c,
                                           logic [ByteWidth-1:0] v);
      result_type r;
      r.kind  = k;
      r.code  = c;
      r.value = v;
      return r;
   endfunction

   assign bytes_dec = bytes_rem_ff - AreaSizeWidth'(1);
   assign data_dec  = data_rem_ff - AreaSizeWidth'(1);
   assign opt_len   = {len_hi_ff, data_byte};
   assign alg_list  = (code_ff == OPT_DAU) || (code_ff == OPT_DHU) || (code_ff == OPT_N3U);

   always_comb begin
      if (data_byte >= TWO_HUNDRED) begin
         hund     = 2'd2;
         hund_sub = TWO_HUNDRED;
      end else if (data_byte >= HUNDRED) begin
         hund     = 2'd1;
         hund_sub = HUNDRED;
      end else begin
         hund     = 2'd0;
         hund_sub = '0;
      end
   end

   // For values below 100, (x * 205) >> 11 equals x / 10.
   assign rem       = data_byte - hund_sub;
   assign tens_prod = {8'd0, rem} * 16'd205;
   assign tens      = tens_prod[14:11];
   assign tens_x10  = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
   assign ones      = rem - tens_x10;

   always_comb begin
      phase_in     = phase_ff;
      bytes_rem_in = bytes_rem_ff;
      code_in      = code_ff;
      data_rem_in  = data_rem_ff;
      len_hi_in    = len_hi_ff;
      do_boundary  = 1'b0;
      n            = '0;
      res          = '0;

      if (accept) begin
         if (kind == KIND_START) begin
            bytes_rem_in = area_size;
            code_in      = '0;
            data_rem_in  = '0;
            do_boundary  = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_CODE_HI: begin
                  code_in      = {data_byte, 8'd0};
                  bytes_rem_in = bytes_dec;
                  phase_in     = PH_CODE_LO;
               end
               PH_CODE_LO: begin
                  code_in      = {code_ff[15:8], data_byte};
                  bytes_rem_in = bytes_dec;
                  phase_in     = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  len_hi_in    = data_byte;
                  bytes_rem_in = bytes_dec;
                  phase_in     = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  bytes_rem_in = bytes_dec;
                  if (opt_len > bytes_dec) begin
                     res[n[ResIdxWidth-1:0]] = make_res(RK_BADLEN, code_ff, '0);
                     n        = n + 3'd1;
                     phase_in = PH_IDLE;
                  end else if (opt_len == '0) begin
                     do_boundary = 1'b1;
                  end else begin
                     data_rem_in = opt_len;
                     if ((code_ff != OPT_NSID) && !alg_list) begin
                        res[n[ResIdxWidth-1:0]] = make_res(RK_OTHER, code_ff, '0);
                        n = n + 3'd1;
                     end
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  bytes_rem_in = bytes_dec;
                  data_rem_in  = data_dec;
                  if (code_ff == OPT_NSID) begin
                     res[n[ResIdxWidth-1:0]] = make_res(RK_NSID, code_ff, data_byte);
                     n = n + 3'd1;
                  end else if (alg_list) begin
                     if (data_byte >= HUNDRED) begin
                        res[n[ResIdxWidth-1:0]] =
                           make_res(RK_ALG, code_ff, ASCII_ZERO + {6'd0, hund});
                        n = n + 3'd1;
                     end
                     if (data_byte >= TEN) begin
                        res[n[ResIdxWidth-1:0]] =
                           make_res(RK_ALG, code_ff, ASCII_ZERO + {4'd0, tens});
                        n = n + 3'd1;
                     end
                     res[n[ResIdxWidth-1:0]] = make_res(RK_ALG, code_ff, ASCII_ZERO + ones);
                     n = n + 3'd1;
                     if (data_dec != '0) begin
                        res[n[ResIdxWidth-1:0]] = make_res(RK_ALG, code_ff, ASCII_COMMA);
                        n = n + 3'd1;
                     end
                  end
                  if (data_dec == '0) begin
                     do_boundary = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end

         // At an option boundary the remaining byte count decides what follows.
         if (do_boundary) begin
            if (bytes_rem_in == '0) begin
               res[n[ResIdxWidth-1:0]] = make_res(RK_DONE, '0, '0);
               n        = n + 3'd1;
               phase_in = PH_IDLE;
            end else if (bytes_rem_in < MinHeader) begin
               res[n[ResIdxWidth-1:0]] = make_res(RK_SHORT, '0, '0);
               n        = n + 3'd1;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_CODE_HI;
            end
         end
      end
   end

   assign push            = accept && (n != '0);
   assign bundle.res      = res;
   assign bundle.last_idx = ResIdxWidth'(n - 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bytes_rem_ff <= '0;
         code_ff      <= '0;
         data_rem_ff  <= '0;
         len_hi_ff    <= '0;
      end else begin
         phase_ff     <= phase_in;
         bytes_rem_ff <= bytes_rem_in;
         code_ff      <= code_in;
         data_rem_ff  <= data_rem_in;
         len_hi_ff    <= len_hi_in;
      end
   end

endmodule

[rtl/eotp_result_queue.sv]
// Two-entry queue of result bundles, unrolled onto the result channel one beat at a time.
module eotp_result_queue import eotp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  bundle_type  push_bundle,
   output logic        space,
   eotp_rsp_if.source  rsp
);

   bundle_type             slot_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic [ResIdxWidth-1:0] idx_ff, idx_in;

   bundle_type head;
   result_type head_res;
   logic       fire;
   logic       head_done;

   assign head     = slot_ff[rd_ptr_ff];
   assign head_res = head.res[idx_ff];

   assign rsp.valid       = (count_ff != 2'd0);
   assign rsp.result_kind = head_res.kind;
   assign rsp.tlv_code    = head_res.code;
   assign rsp.value       = head_res.value;
   assign rsp.last        = (idx_ff == head.last_idx);

   assign fire      = rsp.valid && rsp.ready;
   assign head_done = fire && rsp.last;
   assign space     = (count_ff != 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_done ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, head_done};
      if (head_done) begin
         idx_in = '0;
      end else if (fire) begin
         idx_in = idx_ff + ResIdxWidth'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
      end
   end

endmodule
